// ===== rtl/ccr_pkg.sv =====
// shared constants, codes and controller/datapath interface types
// for the circle canvas rasterizer; no dependencies
package ccr_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 8;

  localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);

  localparam int COORD_W    = 24;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int BYTE_W     = 8;
  localparam int ACT_W      = 2;
  localparam int PSEL_W     = 9;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 16;

  // pixel position in fixed point, signed difference, magnitude, square
  localparam int P_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + FRAC_BITS;
  localparam int D_W   = ((COORD_W > P_W + 1) ? COORD_W : P_W + 1) + 1;
  localparam int M_W   = D_W - 1;
  localparam int SQ_W  = 2 * M_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int ONE   = 1 << FRAC_BITS;

  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DRAW  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

  localparam logic [CFG_W-1:0]  DIM_RST = 10'd1;
  localparam logic [BYTE_W-1:0] BG_RST  = 8'd32;

  typedef struct packed {
    logic             accept;
    logic             load_r;
    logic             latch_r;
    logic             pix_en;
    logic             clr_we;
    logic             rd_en;
    logic             cap_pix;
    logic             set_bad;
    logic             res_load;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic r_bad;
    logic col_last;
    logic row_last;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/ccr_ctrl.sv =====
// controller state machine: sequences clear sweep, draw setup and pixel
// sweep, pixel read and result hand-off; uses ccr_pkg
module ccr_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [ccr_pkg::ACT_W-1:0] in_action_i,
  output logic                     in_ready_o,
  input  ccr_pkg::sts_t            sts_i,
  output ccr_pkg::cmd_t            cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_WAIT   = 4'd3;
  localparam logic [3:0] S_LATCH  = 4'd4;
  localparam logic [3:0] S_SWEEP  = 4'd5;
  localparam logic [3:0] S_DRAIN  = 4'd6;
  localparam logic [3:0] S_READ   = 4'd7;
  localparam logic [3:0] S_RDWAIT = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [ccr_pkg::COL_W-1:0] COL_END = ccr_pkg::COL_W'(ccr_pkg::MAX_WIDTH - 1);
  localparam logic [ccr_pkg::ROW_W-1:0] ROW_END = ccr_pkg::ROW_W'(ccr_pkg::MAX_HEIGHT - 1);

  logic [3:0]                state_q, state_d;
  logic [ccr_pkg::COL_W-1:0] col_q, col_d;
  logic [ccr_pkg::ROW_W-1:0] row_q, row_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    cmd_o   = '0;
    cmd_o.col = col_q;
    cmd_o.row = row_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          col_d = '0;
          row_d = '0;
          case (in_action_i)
            ccr_pkg::ACT_CLEAR: state_d = S_CLEAR;
            ccr_pkg::ACT_DRAW:  state_d = S_SETUP;
            ccr_pkg::ACT_READ:  state_d = S_READ;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (col_q == COL_END) begin
          col_d = '0;
          if (row_q == ROW_END) begin
            state_d = S_DONE;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      S_SETUP: begin
        if (sts_i.r_bad) begin
          cmd_o.set_bad = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.load_r = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_LATCH;
      end
      S_LATCH: begin
        cmd_o.latch_r = 1'b1;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        cmd_o.pix_en = 1'b1;
        if (sts_i.col_last) begin
          col_d = '0;
          if (sts_i.row_last) begin
            state_d = S_DRAIN;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_RDWAIT;
      end
      S_RDWAIT: begin
        cmd_o.cap_pix = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

// ===== rtl/ccr_datapath.sv =====
// datapath: configuration registers, request registers, distance pipeline,
// canvas memory and result register; uses ccr_pkg
module ccr_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ccr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ccr_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic [ccr_pkg::IN_DATA_W-1:0]    in_data_i,
  input  ccr_pkg::cmd_t                    cmd_i,
  output ccr_pkg::sts_t                    sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [ccr_pkg::OUT_DATA_W-1:0]   out_data_o
);

  localparam int D_W  = ccr_pkg::D_W;
  localparam int M_W  = ccr_pkg::M_W;
  localparam int SQ_W = ccr_pkg::SQ_W;
  localparam int A_W  = ccr_pkg::ADDR_W;

  function automatic logic [M_W-1:0] mag(input logic signed [D_W-1:0] v);
    mag = v[D_W-1] ? M_W'(-v) : M_W'(v);
  endfunction

  function automatic logic [A_W-1:0] pix_addr(input logic [ccr_pkg::ROW_W-1:0] r,
                                              input logic [ccr_pkg::COL_W-1:0] c);
    pix_addr = A_W'(A_W'(r) * ccr_pkg::MAX_WIDTH + A_W'(c));
  endfunction

  // configuration
  logic [ccr_pkg::CFG_W-1:0]  width_q, height_q;
  logic [ccr_pkg::BYTE_W-1:0] bg_q;
  logic [ccr_pkg::DIM_W-1:0]  w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ccr_pkg::DIM_RST;
      height_q <= ccr_pkg::DIM_RST;
      bg_q     <= ccr_pkg::BG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ccr_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        ccr_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        ccr_pkg::REG_BG:     bg_q     <= cfg_data_i[ccr_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = ccr_pkg::DIM_W'(1);
    end else if (width_q > ccr_pkg::MAX_WIDTH) begin
      w_eff = ccr_pkg::DIM_W'(ccr_pkg::MAX_WIDTH);
    end else begin
      w_eff = ccr_pkg::DIM_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = ccr_pkg::DIM_W'(1);
    end else if (height_q > ccr_pkg::MAX_HEIGHT) begin
      h_eff = ccr_pkg::DIM_W'(ccr_pkg::MAX_HEIGHT);
    end else begin
      h_eff = ccr_pkg::DIM_W'(height_q);
    end
  end

  // request registers
  logic                               filled_q;
  logic signed [ccr_pkg::COORD_W-1:0] cx_q, cy_q, r_q;
  logic [ccr_pkg::BYTE_W-1:0]         paint_q;
  logic [ccr_pkg::PSEL_W-1:0]         pcol_q, prow_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      filled_q <= in_data_i[0];
      cx_q     <= in_data_i[24:1];
      cy_q     <= in_data_i[48:25];
      r_q      <= in_data_i[72:49];
      paint_q  <= in_data_i[80:73];
      pcol_q   <= in_data_i[89:81];
      prow_q   <= in_data_i[98:90];
    end
  end

  // distance pipeline: difference, square, sum and compare
  logic signed [D_W-1:0] px, py;
  logic signed [D_W-1:0] dx_q, dy_q;
  logic                  va_q, vb_q, wr_q;
  logic [A_W-1:0]        addr_a_q, addr_b_q, waddr_q;
  logic [SQ_W-1:0]       dx2_q, dy2_q, r2_q, in2_q;
  logic                  inner_neg_q;
  logic [M_W-1:0]        mx, my;
  logic [ccr_pkg::SUM_W-1:0] d2;
  logic                  in_disk, in_rim, paint_hit;

  assign px = D_W'(cmd_i.col) << ccr_pkg::FRAC_BITS;
  assign py = D_W'(cmd_i.row) << ccr_pkg::FRAC_BITS;
  assign mx = mag(dx_q);
  assign my = mag(dy_q);
  assign d2 = ccr_pkg::SUM_W'(dx2_q) + ccr_pkg::SUM_W'(dy2_q);
  assign in_disk   = (d2 <= ccr_pkg::SUM_W'(r2_q));
  assign in_rim    = in_disk && (inner_neg_q || (d2 > ccr_pkg::SUM_W'(in2_q)));
  assign paint_hit = vb_q && (in_rim || (in_disk && filled_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_r) begin
      dx_q <= D_W'(r_q);
      dy_q <= D_W'(r_q) - D_W'(ccr_pkg::ONE);
    end else begin
      dx_q <= px - D_W'(cx_q);
      dy_q <= py - D_W'(cy_q);
    end
    addr_a_q <= pix_addr(cmd_i.row, cmd_i.col);
    dx2_q    <= mx * mx;
    dy2_q    <= my * my;
    addr_b_q <= addr_a_q;
    waddr_q  <= addr_b_q;
    if (cmd_i.latch_r) begin
      r2_q        <= dx2_q;
      in2_q       <= dy2_q;
      inner_neg_q <= (r_q < ccr_pkg::COORD_W'(ccr_pkg::ONE));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      va_q <= cmd_i.pix_en;
      vb_q <= va_q;
      wr_q <= paint_hit;
    end
  end

  // canvas memory
  logic [ccr_pkg::BYTE_W-1:0] canvas_q [ccr_pkg::MEM_DEPTH];
  logic [ccr_pkg::BYTE_W-1:0] rd_data_q;
  logic [ccr_pkg::BYTE_W-1:0] wdata_q;
  logic [A_W-1:0]             raddr;
  logic                       in_range;

  assign raddr    = pix_addr(ccr_pkg::ROW_W'(prow_q), ccr_pkg::COL_W'(pcol_q));
  assign in_range = (ccr_pkg::DIM_W'(pcol_q) < w_eff) && (ccr_pkg::DIM_W'(prow_q) < h_eff);

  always_ff @(posedge clk_i) begin
    wdata_q <= paint_q;
    if (cmd_i.clr_we) begin
      canvas_q[pix_addr(cmd_i.row, cmd_i.col)] <= bg_q;
    end else if (wr_q) begin
      canvas_q[waddr_q] <= wdata_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= canvas_q[raddr];
    end
  end

  // result register
  logic                       st_q;
  logic [ccr_pkg::BYTE_W-1:0] pix_q;
  logic                       out_valid_q;
  logic                       out_st_q;
  logic [ccr_pkg::BYTE_W-1:0] out_pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      st_q  <= 1'b0;
      pix_q <= '0;
    end else begin
      if (cmd_i.set_bad) begin
        st_q <= 1'b1;
      end
      if (cmd_i.cap_pix) begin
        pix_q <= in_range ? rd_data_q : '0;
      end
    end
    if (cmd_i.res_load) begin
      out_st_q  <= st_q;
      out_pix_q <= pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {7'd0, out_pix_q, out_st_q};

  assign sts_o.r_bad     = r_q[ccr_pkg::COORD_W-1] || (r_q == '0);
  assign sts_o.col_last  = (ccr_pkg::DIM_W'(cmd_i.col) == w_eff - 1'b1);
  assign sts_o.row_last  = (ccr_pkg::DIM_W'(cmd_i.row) == h_eff - 1'b1);
  assign sts_o.pipe_busy = va_q || vb_q || wr_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/circle_canvas_rasterizer_top.sv =====
// top level of the circle canvas rasterizer: joins the controller and the
// datapath; uses ccr_pkg, ccr_ctrl, ccr_datapath
//
// Requests enter on the s_axis channel, tuser carrying the action (clear,
// draw, read); every request gives exactly one result on m_axis.
// Configuration (width, height, background) must be written through cfg_*
// only while the block is idle; the block itself does not enforce this.
// Work per action:
//   clear: writes the background over the whole canvas, one canvas byte per cycle
//   draw:  sweeps the configured width by height, one pixel
//          per cycle through a three stage difference / square / compare
//          pipeline; a radius of zero or less is rejected without a sweep
//   read:  uses the registered memory read port
// One request is worked on at a time; the next is taken as soon as its
// predecessor's result sits in the output register.
// Reset returns the registers to width 1, height 1, background 32; the
// canvas holds no defined content until a clear.
// A stalled receiver holds the result steady; the block then finishes the
// current request and waits before loading the next result.
module circle_canvas_rasterizer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // filled, center_x, center_y, radius, paint, pixel_col, pixel_row, zero pad
  input  logic [ccr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // action
  input  logic [ccr_pkg::ACT_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status, pixel_value, zero pad
  output logic [ccr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [ccr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ccr_pkg::CFG_W-1:0]          cfg_data_i
);

  ccr_pkg::cmd_t cmd;
  ccr_pkg::sts_t sts;

  ccr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ccr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/ccr_checker.sv =====
// port-level checks of the circle canvas rasterizer top level and the
// bind that attaches them; uses ccr_pkg
module ccr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ccr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in work at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // a rejected draw returns no pixel
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
    else $error("rejected draw with pixel value");

  // a result rises only while a request is in work
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without request");

endmodule

bind circle_canvas_rasterizer_top ccr_checker u_ccr_checker (.*);
